// ===== design/fmr_pkg.sv =====
package fmr_pkg;

  // Field widths
  localparam int unsigned ARG_W = 32;
  localparam int unsigned MAG_W = 64;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 5 * ARG_W;
  localparam int unsigned OUT_TDATA_W = 2 * MAG_W;

  // Divider step counter width
  localparam int unsigned CNT_W = $clog2(MAG_W);

  // Operation selector codes
  localparam logic FUNC_FRAC = 1'b0;
  localparam logic FUNC_INT  = 1'b1;

  // Magnitude of a two's complement argument, as unsigned
  function automatic logic [ARG_W-1:0] arg_mag(input logic [ARG_W-1:0] x);
    arg_mag = x[ARG_W-1] ? (~x + 1'b1) : x;
  endfunction

  // Apply a sign to a magnitude
  function automatic logic [MAG_W-1:0] with_sign(input logic [MAG_W-1:0] m,
                                                  input logic neg);
    with_sign = neg ? (~m + 1'b1) : m;
  endfunction

endpackage

// ===== design/fraction_multiply_reduce.sv =====
// A zero denominator or zero numerator skips the divider; otherwise every Euclid
// remainder and both final quotients go through one shared restoring divider at
// one bit a cycle.
// Throughput: one item at a time; the next item is taken once the result is in
// the output register, which holds while m_tready is low. Reset: rst, synchronous,
// active high, clears the sequencer and the output valid; payload is not reset.
module fraction_multiply_reduce (
  input  logic                            clk,
  input  logic                            rst,
  // fields from bit 0: num_a[31:0], den_a[63:32], num_b[95:64], den_b[127:96],
  // integer_factor[159:128]
  input  logic [fmr_pkg::IN_TDATA_W-1:0]  s_tdata,
  // fields from bit 0: func
  input  logic                            s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // fields from bit 0: num_out[63:0], den_out[127:64]
  output logic [fmr_pkg::OUT_TDATA_W-1:0] m_tdata,
  // fields from bit 0: invalid_denominator
  output logic                            m_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready
);
  import fmr_pkg::*;

  typedef enum logic [2:0] {
    IDLE, MUL_N, MUL_D, CHECK, GCD_TEST, DIV, FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_MOD, PH_DIVN, PH_DIVD
  } phase_t;

  state_t state;
  phase_t phase;

  // Operand registers
  logic             func;
  logic [ARG_W-1:0] ma, mda, mb, mdb;
  logic             nneg, dneg;
  logic [MAG_W-1:0] nmag, dmag;
  logic             res_inv;

  // Euclid registers
  logic [MAG_W-1:0] ga, gb;

  // Shared divider
  logic [MAG_W-1:0] quot, rem, dvs;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W:0]   rem_sh;
  logic             fits;
  logic [MAG_W:0]   rem_diff;

  // Shared multiplier
  logic [ARG_W-1:0] mul_l;
  logic [ARG_W-1:0] mul_r;
  logic [MAG_W-1:0] product;

  logic             out_load;

  logic [ARG_W-1:0] in_na, in_da, in_nb, in_db, in_fi;

  assign in_na = s_tdata[ARG_W-1:0];
  assign in_da = s_tdata[2*ARG_W-1:ARG_W];
  assign in_nb = s_tdata[3*ARG_W-1:2*ARG_W];
  assign in_db = s_tdata[4*ARG_W-1:3*ARG_W];
  assign in_fi = s_tdata[5*ARG_W-1:4*ARG_W];

  assign s_tready = (state == IDLE);

  // Pick the multiplier operands: numerators first, then denominators
  assign mul_l   = (state == MUL_N) ? ma : mda;
  assign mul_r   = (state == MUL_N) ? mb : mdb;
  assign product = MAG_W'(mul_l) * MAG_W'(mul_r);

  // One restoring division step
  assign rem_sh   = {rem, quot[MAG_W-1]};
  assign fits     = (rem_sh >= {1'b0, dvs});
  assign rem_diff = rem_sh - {1'b0, dvs};

  // Load the output register when a result is ready and the slot is free
  assign out_load = (state == FINISH) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      phase    <= PH_MOD;
      m_tvalid <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            func  <= s_tuser;
            ma    <= arg_mag(in_na);
            mda   <= arg_mag(in_da);
            nneg  <= in_na[ARG_W-1] ^
                     ((s_tuser == FUNC_INT) ? in_fi[ARG_W-1] : in_nb[ARG_W-1]);
            dneg  <= in_da[ARG_W-1] ^
                     ((s_tuser == FUNC_INT) ? 1'b0 : in_db[ARG_W-1]);
            mb    <= (s_tuser == FUNC_INT) ? arg_mag(in_fi) : arg_mag(in_nb);
            mdb   <= arg_mag(in_db);
            state <= MUL_N;
          end
        end
        MUL_N: begin
          nmag  <= product;
          state <= MUL_D;
        end
        MUL_D: begin
          dmag  <= (func == FUNC_INT) ? MAG_W'(mda) : product;
          state <= CHECK;
        end
        CHECK: begin
          // Zero denominator flags, zero numerator skips reduction
          res_inv <= (dmag == '0);
          ga      <= nmag;
          gb      <= dmag;
          if (dmag == '0 || nmag == '0) begin
            state <= FINISH;
          end else begin
            state <= GCD_TEST;
          end
        end
        GCD_TEST: begin
          // Start the next remainder, or divide the numerator by the gcd
          rem <= '0;
          cnt <= '0;
          if (gb == '0) begin
            quot  <= nmag;
            dvs   <= ga;
            phase <= PH_DIVN;
          end else begin
            quot  <= ga;
            dvs   <= gb;
            phase <= PH_MOD;
          end
          state <= DIV;
        end
        DIV: begin
          if (cnt == CNT_W'(MAG_W - 1)) begin
            unique case (phase)
              PH_MOD: begin
                ga    <= gb;
                gb    <= fits ? rem_diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
                state <= GCD_TEST;
              end
              PH_DIVN: begin
                nmag  <= {quot[MAG_W-2:0], fits};
                quot  <= dmag;
                rem   <= '0;
                cnt   <= '0;
                phase <= PH_DIVD;
                state <= DIV;
              end
              PH_DIVD: begin
                dmag  <= {quot[MAG_W-2:0], fits};
                state <= FINISH;
              end
              default: state <= FINISH;
            endcase
          end else begin
            // Shift in one quotient bit
            quot <= {quot[MAG_W-2:0], fits};
            rem  <= fits ? rem_diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
            cnt  <= cnt + 1'b1;
          end
        end
        FINISH: begin
          // Load the output register once it is free
          if (out_load) begin
            m_tuser <= res_inv;
            if (res_inv) begin
              m_tdata <= '0;
            end else begin
              m_tdata <= {with_sign(dmag, dneg), with_sign(nmag, nneg)};
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
